// ===== sv/replacement_selection_run_generator_defines.svh =====
// assertion macros for the run generator checker
// no dependencies
`ifndef REPLACEMENT_SELECTION_RUN_GENERATOR_DEFINES_SVH
`define REPLACEMENT_SELECTION_RUN_GENERATOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define RSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsrg check failed");
// next-cycle implication
`define RSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsrg check failed");
`endif

// ===== sv/rsrg_pkg.sv =====
// shared types and constants for the run generator
// no dependencies
package rsrg_pkg;
    localparam int HEAP_ENTRIES_DEF = 16;
    localparam int MAX_TAPES_DEF    = 16;
    localparam int KEY_W = 16;
    localparam int ID_W  = 32;
    localparam int CFG_W = 5;
    localparam int TAPE_W = 5;

    localparam logic [0:0] REG_ACTIVE = 1'b0;
    localparam logic [0:0] REG_TAPES  = 1'b1;

    typedef enum logic [2:0] {
        t_st_idle, t_st_decide, t_st_emit, t_st_insert
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;     // latch input item
        logic pop;         // remove front entry, present it
        logic close_run;   // present marker, advance tape, unmark
        logic final_mark;  // present final marker
        logic ins_step;    // one shift step of insertion
        logic ins_done;    // write new item at slot
        logic set_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_flush;
        logic empty;
        logic full;
        logic front_marked;
        logic ins_more;   // insertion still needs a shift step
        logic out_busy;   // output register holds untaken result
    } t_stat;
endpackage

// ===== sv/rsrg_datapath.sv =====
// selection store, output register and tape counter
// depends on rsrg_pkg
module rsrg_datapath #(
    parameter int HEAP_ENTRIES = rsrg_pkg::HEAP_ENTRIES_DEF,
    parameter int MAX_TAPES = rsrg_pkg::MAX_TAPES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [rsrg_pkg::CFG_W-1:0] i_cfg_data,
    input  logic i_in_flush,
    input  logic [rsrg_pkg::KEY_W-1:0] i_in_key,
    input  logic [rsrg_pkg::ID_W-1:0] i_in_id,
    input  rsrg_pkg::t_cmd i_cmd,
    output rsrg_pkg::t_stat o_stat,
    input  logic i_out_take,
    output logic o_out_valid,
    output logic [rsrg_pkg::KEY_W-1:0] o_out_key,
    output logic [rsrg_pkg::ID_W-1:0] o_out_id,
    output logic [rsrg_pkg::TAPE_W-1:0] o_out_tape,
    output logic o_out_eor,
    output logic o_out_last
);
    import rsrg_pkg::*;
    localparam int CW = $clog2(HEAP_ENTRIES + 1);
    localparam int AW = $clog2(HEAP_ENTRIES);

    logic [KEY_W-1:0] r_key [HEAP_ENTRIES];
    logic [ID_W-1:0]  r_id  [HEAP_ENTRIES];
    logic [HEAP_ENTRIES-1:0] r_mark;
    logic [CW-1:0] r_count, r_pos;
    logic [TAPE_W-1:0] r_tape;
    logic [CFG_W-1:0] r_active, r_tapes;
    logic r_flush, r_nmark;
    logic [KEY_W-1:0] r_nkey;
    logic [ID_W-1:0] r_nid;
    logic [CW-1:0] w_cap;
    logic [TAPE_W-1:0] w_ntapes;
    logic [AW-1:0] w_pm1;
    logic w_prev_gt;

    // clamp configuration to legal range
    always_comb begin
        if (r_active == '0) w_cap = CW'(1);
        else if (32'(r_active) > HEAP_ENTRIES) w_cap = CW'(HEAP_ENTRIES);
        else w_cap = CW'(r_active);
        if (r_tapes == '0) w_ntapes = TAPE_W'(1);
        else if (32'(r_tapes) > MAX_TAPES) w_ntapes = TAPE_W'(MAX_TAPES);
        else w_ntapes = TAPE_W'(r_tapes);
    end

    assign w_pm1 = AW'(r_pos - CW'(1));
    assign w_prev_gt = (r_pos != '0) && ((r_mark[w_pm1] && !r_nmark) ||
        (r_mark[w_pm1] == r_nmark && r_key[w_pm1] > r_nkey));

    assign o_stat.is_flush = r_flush;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full = (r_count >= w_cap);
    assign o_stat.front_marked = r_mark[0];
    assign o_stat.ins_more = w_prev_gt;
    assign o_stat.out_busy = o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_W'(16);
            r_tapes <= CFG_W'(4);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ACTIVE) r_active <= i_cfg_data;
            else r_tapes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mark <= '0;
            r_tape <= TAPE_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            // new results are only produced while the register is empty
            if (i_out_take && o_out_valid) o_out_valid <= 1'b0;
            if (i_cmd.load_in) begin
                r_flush <= i_in_flush;
                r_nkey <= i_in_key;
                r_nid <= i_in_id;
                r_nmark <= 1'b0;
                r_pos <= r_count;
            end
            if (i_cmd.pop) begin
                o_out_valid <= 1'b1;
                o_out_key <= r_key[0];
                o_out_id <= r_id[0];
                o_out_tape <= r_tape;
                o_out_eor <= 1'b0;
                o_out_last <= i_cmd.set_last;
                r_nmark <= (r_nkey < r_key[0]);
                for (int i = 1; i < HEAP_ENTRIES; i++) begin
                    r_key[i-1] <= r_key[i];
                    r_id[i-1] <= r_id[i];
                    r_mark[i-1] <= r_mark[i];
                end
                r_count <= r_count - CW'(1);
                r_pos <= r_count - CW'(1);
            end
            if (i_cmd.close_run || i_cmd.final_mark) begin
                o_out_valid <= 1'b1;
                o_out_key <= '0;
                o_out_id <= '0;
                o_out_tape <= r_tape;
                o_out_eor <= 1'b1;
                o_out_last <= i_cmd.set_last;
            end
            if (i_cmd.close_run) begin
                r_mark <= '0;
                if (r_tape < w_ntapes) r_tape <= r_tape + TAPE_W'(1);
                else r_tape <= TAPE_W'(1);
            end
            if (i_cmd.ins_step) begin
                r_key[AW'(r_pos)] <= r_key[w_pm1];
                r_id[AW'(r_pos)] <= r_id[w_pm1];
                r_mark[AW'(r_pos)] <= r_mark[w_pm1];
                r_pos <= r_pos - CW'(1);
            end
            if (i_cmd.ins_done) begin
                r_key[AW'(r_pos)] <= r_nkey;
                r_id[AW'(r_pos)] <= r_nid;
                r_mark[AW'(r_pos)] <= r_nmark;
                r_count <= r_count + CW'(1);
            end
        end
    end
endmodule

// ===== sv/rsrg_ctrl.sv =====
// sequencer for store, evict, close and flush steps
// depends on rsrg_pkg
module rsrg_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  rsrg_pkg::t_stat i_stat,
    output rsrg_pkg::t_cmd o_cmd
);
    import rsrg_pkg::*;
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_st_idle: if (i_in_valid) begin
                n_state = t_st_decide;
            end
            t_st_decide: begin
                if (i_stat.is_flush) n_state = t_st_emit;
                else if (!i_stat.full) n_state = t_st_insert;
                else n_state = t_st_emit;
            end
            t_st_emit: if (!i_stat.out_busy) begin
                if (i_stat.is_flush) begin
                    if (i_stat.empty) n_state = t_st_idle;
                end else if (!i_stat.front_marked) begin
                    n_state = t_st_insert;
                end
            end
            t_st_insert: if (!i_stat.ins_more) n_state = t_st_idle;
            default: n_state = t_st_idle;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == t_st_idle);
        case (r_state)
            t_st_idle: o_cmd.load_in = i_in_valid;
            t_st_emit: if (!i_stat.out_busy) begin
                if (i_stat.is_flush) begin
                    if (i_stat.empty) begin
                        o_cmd.final_mark = 1'b1;
                        o_cmd.set_last = 1'b1;
                    end else if (i_stat.front_marked) o_cmd.close_run = 1'b1;
                    else o_cmd.pop = 1'b1;
                end else if (i_stat.front_marked) o_cmd.close_run = 1'b1;
                else begin
                    o_cmd.pop = 1'b1;
                    o_cmd.set_last = 1'b1;
                end
            end
            t_st_insert: begin
                if (i_stat.ins_more) o_cmd.ins_step = 1'b1;
                else o_cmd.ins_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_st_idle;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== sv/replacement_selection_run_generator.sv =====
// top level of the replacement-selection run generator
// depends on rsrg_pkg, rsrg_ctrl, rsrg_datapath
//
// usage:
//  s_axis carries one item per transfer: tuser = kind (1 = flush),
//  tdata = {record_id, key}. m_axis carries results: tdata = out_key,
//  out_id, tape, end_of_run packed from bit 0 up; tlast marks the last
//  result caused by an input item.
//  config: i_cfg_we with i_cfg_idx 0 = active_entries, 1 = tape_count,
//  written only while idle.
//  timing: one item at a time; the next item is taken only once the
//  sequencer is back in idle. a record while the store fills moves past
//  up to the store depth of entries, one shift step each; an evicting
//  record first emits a result, and a run marker too if a run closes.
//  a flush emits every stored record and run marker, then a final marker.
//  the insertion shift walk sets the per-item cost.
//  reset: store empty, tape one, active_entries 16, tape_count 4.
//  a stalled receiver holds the single output register; the sequencer
//  waits until the result is taken before producing the next.
module replacement_selection_run_generator #(
    parameter int HEAP_ENTRIES = rsrg_pkg::HEAP_ENTRIES_DEF,
    parameter int MAX_TAPES = rsrg_pkg::MAX_TAPES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [rsrg_pkg::CFG_W-1:0] i_cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[15:0], record_id[47:16]
    input  logic s_axis_tuser,          // kind
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_key, out_id, tape, end_of_run, zero pad
    output logic m_axis_tlast
);
    import rsrg_pkg::*;
    t_cmd w_cmd;
    t_stat w_stat;
    logic [KEY_W-1:0] w_key;
    logic [ID_W-1:0] w_id;
    logic [TAPE_W-1:0] w_tape;
    logic w_eor;

    rsrg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    rsrg_datapath #(.HEAP_ENTRIES(HEAP_ENTRIES), .MAX_TAPES(MAX_TAPES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_flush(s_axis_tuser), .i_in_key(s_axis_tdata[15:0]),
        .i_in_id(s_axis_tdata[47:16]),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_out_take(m_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_out_key(w_key), .o_out_id(w_id),
        .o_out_tape(w_tape), .o_out_eor(w_eor), .o_out_last(m_axis_tlast)
    );

    // pack result fields from bit 0 up
    assign m_axis_tdata = {2'b00, w_eor, w_tape, w_id, w_key};
endmodule

// ===== sv/rsrg_checker.sv =====
// port-level checker for the run generator, bound to the top level
// depends on replacement_selection_run_generator_defines.svh
`include "replacement_selection_run_generator_defines.svh"
module rsrg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic m_axis_tlast
);
    // markers carry no record
    `RSRG_ASSERT_IMP(a_marker_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[53], m_axis_tdata[47:0] == 48'd0)
    // tape never zero
    `RSRG_ASSERT_IMP(a_tape_nz, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[52:48] != 5'd0)
    // a new item is not taken while a result that is not the last of its item waits
    `RSRG_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && !m_axis_tlast, !s_axis_tready)
    // accepted item blocks the input next cycle
    `RSRG_ASSERT_NXT(a_one_at_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind replacement_selection_run_generator rsrg_checker u_rsrg_checker (.*);

// ===== test/replacement_selection_run_generator_checker.sv =====
// checker for the run generator: watches both stream channels, predicts the
// result stream from accepted items and configuration writes, and counts mismatches
// depends on rsrg_pkg
module replacement_selection_run_generator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [rsrg_pkg::CFG_W-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rsrg_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
        logic [TAPE_W-1:0] tape;
        logic              eor;
        logic              last;
    } t_emitted;

    t_emitted          sorted_out_q[$];
    logic [KEY_W-1:0]  sel_key[HEAP_ENTRIES_DEF];
    logic [ID_W-1:0]   sel_id[HEAP_ENTRIES_DEF];
    logic              sel_mark[HEAP_ENTRIES_DEF];
    int                sel_count;
    int                tape_now;
    logic [CFG_W-1:0]  capacity_reg;
    logic [CFG_W-1:0]  tapes_reg;

    assign o_pending = sorted_out_q.size();

    function automatic int capacity();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > HEAP_ENTRIES_DEF) return HEAP_ENTRIES_DEF;
        return capacity_reg;
    endfunction

    function automatic int tape_limit();
        if (tapes_reg == 0) return 1;
        if (tapes_reg > MAX_TAPES_DEF) return MAX_TAPES_DEF;
        return tapes_reg;
    endfunction

    // unmarked before marked, ascending key, fifo among equal keys
    function automatic void store_record(logic [KEY_W-1:0] k, logic [ID_W-1:0] id,
                                         logic m);
        int pos;
        pos = sel_count;
        if (sel_count >= HEAP_ENTRIES_DEF) return;
        while (pos > 0 && (sel_mark[pos-1] > m ||
               (sel_mark[pos-1] == m && sel_key[pos-1] > k))) begin
            sel_key[pos] = sel_key[pos-1];
            sel_id[pos] = sel_id[pos-1];
            sel_mark[pos] = sel_mark[pos-1];
            pos--;
        end
        sel_key[pos] = k;
        sel_id[pos] = id;
        sel_mark[pos] = m;
        sel_count++;
    endfunction

    function automatic void emit(logic [KEY_W-1:0] k, logic [ID_W-1:0] id, logic eor);
        t_emitted e;
        e.key = k;
        e.id = id;
        e.tape = TAPE_W'(tape_now);
        e.eor = eor;
        e.last = 1'b0;
        sorted_out_q.push_back(e);
    endfunction

    function automatic void evict_front(output logic [KEY_W-1:0] k);
        emit(sel_key[0], sel_id[0], 1'b0);
        k = sel_key[0];
        for (int i = 1; i < sel_count; i++) begin
            sel_key[i-1] = sel_key[i];
            sel_id[i-1] = sel_id[i];
            sel_mark[i-1] = sel_mark[i];
        end
        sel_count--;
    endfunction

    // end-of-run marker, next tape, everything back into the current run
    function automatic void end_run();
        emit('0, '0, 1'b1);
        tape_now = (tape_now < tape_limit()) ? tape_now + 1 : 1;
        for (int i = 0; i < sel_count; i++) sel_mark[i] = 1'b0;
    endfunction

    function automatic void predict_item(logic flush, logic [KEY_W-1:0] k,
                                         logic [ID_W-1:0] id);
        logic [KEY_W-1:0] gone;
        int before_n;
        before_n = sorted_out_q.size();
        if (!flush) begin
            if (sel_count < capacity()) begin
                store_record(k, id, 1'b0);
                return;
            end
            if (sel_mark[0]) end_run();
            evict_front(gone);
            store_record(k, id, k < gone);
        end else begin
            while (sel_count > 0) begin
                if (sel_mark[0]) end_run();
                else evict_front(gone);
            end
            emit('0, '0, 1'b1);
        end
        if (sorted_out_q.size() > before_n) sorted_out_q[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_emitted got, want;
        if (!i_rst_n) begin
            sorted_out_q.delete();
            sel_count = 0;
            tape_now = 1;
            capacity_reg <= 5'd16;
            tapes_reg <= 5'd4;
            o_fail_count <= 0;
            for (int i = 0; i < HEAP_ENTRIES_DEF; i++) sel_mark[i] = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ACTIVE) capacity_reg <= i_cfg_data;
                else tapes_reg <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[52:48],
                       m_axis_tdata[53], m_axis_tlast};
                if (sorted_out_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sorted_out_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: key %h/%h id %h/%h tape %0d/%0d",
                                      " eor %b/%b last %b/%b"},
                                want.key, got.key, want.id, got.id, want.tape, got.tape,
                                want.eor, got.eor, want.last, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/replacement_selection_run_generator_test.sv =====
// stimulus and verdict for the replacement-selection run generator
// depends on rsrg_pkg, the block and replacement_selection_run_generator_checker
module replacement_selection_run_generator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rsrg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = REG_ACTIVE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // key[15:0], record_id[47:16]
    logic s_axis_tuser = 1'b0;        // kind
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // out_key, out_id, tape, end_of_run, pad
    logic m_axis_tlast;
    int fail_count, pending, cycles;
    bit quiet_phase;                  // no idling on either side
    int hold_off;                     // cycles the receiver still blocks

    always #2 i_clk = ~i_clk;

    replacement_selection_run_generator dut (.*);

    replacement_selection_run_generator_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // cycle limit watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end
    initial cycles = 0;

    // receiver: random stalls, plus a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= 20);
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one item, with random gap before it; waits for the transfer
    task automatic send_item(logic flush, logic [15:0] k, logic [31:0] id);
        while (!quiet_phase && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= flush;
        s_axis_tdata <= {id, k};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // a filling record leaves nothing queued but may still be shifting
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int key_span);
        for (int i = 0; i < n; i++)
            send_item($urandom_range(15) == 0, 16'($urandom_range(key_span)), $urandom);
        send_item(1'b1, 16'($urandom), $urandom);
        drain_results();
    endtask

    initial begin
        quiet_phase = 1'b0;
        hold_off = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small store to get evictions and runs quickly
        write_reg(REG_ACTIVE, 5'd3);
        write_reg(REG_TAPES, 5'd2);
        send_item(1'b1, 16'h0, 32'h0);          // flush on empty store
        send_item(1'b0, 16'hFFFF, 32'hFFFFFFFF);
        send_item(1'b0, 16'h0000, 32'h00000000);
        send_item(1'b0, 16'h8000, 32'hA5A5A5A5);
        send_item(1'b0, 16'h0001, 32'h5A5A5A5A); // above evicted key: same run
        send_item(1'b0, 16'h0000, 32'h11111111); // equal keys keep order
        send_item(1'b0, 16'h0000, 32'h22222222);
        send_item(1'b0, 16'h0000, 32'h33333333);
        send_item(1'b0, 16'h0000, 32'h44444444);
        send_item(1'b1, 16'hFFFF, 32'hFFFFFFFF);
        drain_results();

        // capacity lowered below the fill level
        write_reg(REG_ACTIVE, 5'd16);
        for (int i = 0; i < 8; i++) send_item(1'b0, 16'($urandom), $urandom);
        drain_results();
        write_reg(REG_ACTIVE, 5'd2);
        write_reg(REG_TAPES, 5'd1);
        for (int i = 0; i < 4; i++) send_item(1'b0, 16'($urandom), $urandom);
        send_item(1'b1, 16'h0, 32'h0);
        drain_results();

        // out-of-range register values, current tape above the tape count
        write_reg(REG_TAPES, 5'd31);
        write_reg(REG_ACTIVE, 5'd0);
        random_phase(10, 255);
        write_reg(REG_ACTIVE, 5'd31);
        write_reg(REG_TAPES, 5'd0);
        random_phase(20, 65535);

        // long receiver hold-off while the sender keeps offering
        write_reg(REG_ACTIVE, 5'd1);
        write_reg(REG_TAPES, 5'd16);
        hold_off = 300;
        random_phase(20, 65535);

        // random phases over several settings, one without idling
        write_reg(REG_ACTIVE, 5'd4);
        write_reg(REG_TAPES, 5'd3);
        random_phase(40, 15);
        quiet_phase = 1'b1;
        write_reg(REG_ACTIVE, 5'd16);
        write_reg(REG_TAPES, 5'd4);
        random_phase(40, 65535);
        quiet_phase = 1'b0;
        write_reg(REG_ACTIVE, 5'd1);
        write_reg(REG_TAPES, 5'd16);
        random_phase(30, 1023);
        write_reg(REG_ACTIVE, 5'($urandom_range(16, 1)));
        write_reg(REG_TAPES, 5'($urandom_range(16, 1)));
        random_phase(40, 65535);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/rsrg_pkg.sv
sv/rsrg_datapath.sv
sv/rsrg_ctrl.sv
sv/replacement_selection_run_generator.sv
sv/rsrg_checker.sv
test/replacement_selection_run_generator_checker.sv
test/replacement_selection_run_generator_test.sv
